// ----- rtl/lst_pkg.sv -----
// Shared types and constants for the link-state table.
// Used by the channel interfaces and by the top level link_state_table.
`default_nettype none

package lst_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int ENTRY_CNT_W = 7;

    localparam logic [1:0] REQ_LOOKUP = 2'd0;
    localparam logic [1:0] REQ_ADD    = 2'd1;
    localparam logic [1:0] REQ_REMOVE = 2'd2;

    localparam logic [2:0] ST_FOUND     = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_UPDATED   = 3'd2;
    localparam logic [2:0] ST_ADDED     = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;
    localparam logic [2:0] ST_REMOVED   = 3'd5;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] ls_id;
        logic [31:0] adv_rtr;
        logic [7:0]  lsa_kind;
        logic [31:0] seq_number;
        logic [15:0] lsa_age;
    } t_req;

    typedef struct packed {
        logic [2:0]             status;
        logic [7:0]             found_kind;
        logic [31:0]            found_seq;
        logic [15:0]            found_age;
        logic [ENTRY_CNT_W-1:0] entry_count;
    } t_res;

    // One stored table entry.
    typedef struct packed {
        logic [31:0] ls_id;
        logic [31:0] adv_rtr;
        logic [7:0]  lsa_kind;
        logic [31:0] seq_number;
        logic [15:0] lsa_age;
    } t_rec;

endpackage

`default_nettype wire

// ----- rtl/lst_req_if.sv -----
// Request channel: valid/ready handshake carrying one table request.
// Depends on lst_pkg for the payload type.
`default_nettype none

interface lst_req_if;
    logic          valid;
    logic          ready;
    lst_pkg::t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/lst_res_if.sv -----
// Result channel: valid/ready handshake carrying one table result.
// Depends on lst_pkg for the payload type.
`default_nettype none

interface lst_res_if;
    logic          valid;
    logic          ready;
    lst_pkg::t_res data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/link_state_table.sv -----
// Link-state table: one request in, one result out, through a single-port-read memory.
// The request is compared against the entries one at a time, and a remove then moves the
// later entries down one slot; the result register may stay full while the receiver stalls.
// The next request is accepted in the cycle after the result is loaded; the memory read
// port serves one entry per cycle. Synchronous active-low reset empties the table;
// contents stay.
`default_nettype none

module link_state_table (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    lst_req_if.sink    i_req,
    lst_res_if.source  o_res
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_SHIFT = 4'b0100,
        S_FIN   = 4'b1000
    } t_state;

    t_state                     r_state, n_state;
    lst_pkg::t_req              r_req, n_req;
    logic [lst_pkg::CNT_W-1:0]  r_idx, n_idx;
    logic [lst_pkg::IDX_W-1:0]  r_cmp_idx, n_cmp_idx;
    logic                       r_pend, n_pend;
    logic [lst_pkg::CNT_W-1:0]  r_count, n_count;
    logic [2:0]                 r_status, n_status;
    logic [7:0]                 r_kind, n_kind;
    logic [31:0]                r_seq, n_seq;
    logic [15:0]                r_age, n_age;
    logic                       r_out_valid, n_out_valid;
    lst_pkg::t_res              r_out, n_out;

    lst_pkg::t_rec              r_mem [lst_pkg::MAX_ENTRIES];
    lst_pkg::t_rec              r_rd;

    logic                       wr_en;
    logic [lst_pkg::IDX_W-1:0]  wr_addr;
    lst_pkg::t_rec              wr_data;
    logic                       hit;
    logic                       more;

    // The entry read last cycle is compared while the next one is being read.
    assign hit  = r_pend
               && (r_rd.ls_id == r_req.ls_id)
               && (r_rd.adv_rtr == r_req.adv_rtr);
    assign more = (r_idx < r_count);

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_idx       = r_idx;
        n_cmp_idx   = r_cmp_idx;
        n_pend      = r_pend;
        n_count     = r_count;
        n_status    = r_status;
        n_kind      = r_kind;
        n_seq       = r_seq;
        n_age       = r_age;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        wr_en       = 1'b0;
        wr_addr     = r_cmp_idx;
        wr_data.ls_id      = r_req.ls_id;
        wr_data.adv_rtr    = r_req.adv_rtr;
        wr_data.lsa_kind   = r_req.lsa_kind;
        wr_data.seq_number = r_req.seq_number;
        wr_data.lsa_age    = r_req.lsa_age;

        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                n_idx  = '0;
                n_pend = 1'b0;
                if (i_req.valid) begin
                    n_req    = i_req.data;
                    n_status = lst_pkg::ST_NOT_FOUND;
                    n_kind   = '0;
                    n_seq    = '0;
                    n_age    = '0;
                    n_state  = S_SCAN;
                end
            end
            S_SCAN: begin
                if (hit) begin
                    n_pend  = 1'b0;
                    n_state = S_FIN;
                    case (r_req.req_type)
                        lst_pkg::REQ_LOOKUP: begin
                            n_status = lst_pkg::ST_FOUND;
                            n_kind   = r_rd.lsa_kind;
                            n_seq    = r_rd.seq_number;
                            n_age    = r_rd.lsa_age;
                        end
                        lst_pkg::REQ_ADD: begin
                            wr_en    = 1'b1;
                            n_status = lst_pkg::ST_UPDATED;
                        end
                        lst_pkg::REQ_REMOVE: begin
                            // r_idx already points one past the hit: the first source.
                            n_state = S_SHIFT;
                        end
                        default: begin
                            n_status = lst_pkg::ST_NOT_FOUND;
                        end
                    endcase
                end else if (more) begin
                    n_pend    = 1'b1;
                    n_cmp_idx = r_idx[lst_pkg::IDX_W-1:0];
                    n_idx     = r_idx + lst_pkg::CNT_W'(1);
                end else begin
                    n_pend  = 1'b0;
                    n_state = S_FIN;
                    if (r_req.req_type == lst_pkg::REQ_ADD) begin
                        if (r_count < lst_pkg::CNT_W'(lst_pkg::MAX_ENTRIES)) begin
                            wr_en    = 1'b1;
                            wr_addr  = r_count[lst_pkg::IDX_W-1:0];
                            n_count  = r_count + lst_pkg::CNT_W'(1);
                            n_status = lst_pkg::ST_ADDED;
                        end else begin
                            n_status = lst_pkg::ST_FULL;
                        end
                    end
                end
            end
            S_SHIFT: begin
                // Each entry read here is written back one slot lower in the following cycle.
                if (r_pend) begin
                    wr_en   = 1'b1;
                    wr_addr = r_cmp_idx - lst_pkg::IDX_W'(1);
                    wr_data = r_rd;
                end
                if (more) begin
                    n_pend    = 1'b1;
                    n_cmp_idx = r_idx[lst_pkg::IDX_W-1:0];
                    n_idx     = r_idx + lst_pkg::CNT_W'(1);
                end else begin
                    n_pend   = 1'b0;
                    n_count  = r_count - lst_pkg::CNT_W'(1);
                    n_status = lst_pkg::ST_REMOVED;
                    n_state  = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid       = 1'b1;
                    n_out.status      = r_status;
                    n_out.found_kind  = r_kind;
                    n_out.found_seq   = r_seq;
                    n_out.found_age   = r_age;
                    n_out.entry_count = lst_pkg::ENTRY_CNT_W'(r_count);
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pend      <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req     <= n_req;
        r_idx     <= n_idx;
        r_cmp_idx <= n_cmp_idx;
        r_status  <= n_status;
        r_kind    <= n_kind;
        r_seq     <= n_seq;
        r_age     <= n_age;
        r_out     <= n_out;
    end

    // Entry memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd <= r_mem[r_idx[lst_pkg::IDX_W-1:0]];
    end

    assign i_req.ready = (r_state == S_IDLE);
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

endmodule

`default_nettype wire

// ----- test/tb_link_state_table.sv -----
// Testbench for link_state_table: directed and random table requests with a
// scoreboard that keeps its own copy of the table. Needs lst_pkg, lst_req_if,
// lst_res_if and the link_state_table RTL.
`timescale 1ns / 1ps

module tb_link_state_table;
    import lst_pkg::*;

    localparam logic [1:0] REQ_UNKNOWN = 2'd3;
    localparam int KEY_POOL = 72;
    localparam int REPORT_LIMIT = 10;

    // Keeps a copy of the link-state table and the results it predicts.
    class link_table_model;
        t_rec        entries[MAX_ENTRIES];
        int unsigned used;
        t_res        expected_results[$];
        int unsigned mismatch_count;

        function new();
            used = 0;
            mismatch_count = 0;
        endfunction

        function int find_key(logic [31:0] id, logic [31:0] rtr);
            for (int i = 0; i < used; i++) begin
                if (entries[i].ls_id == id && entries[i].adv_rtr == rtr)
                    return i;
            end
            return -1;
        endfunction

        function void note_request(t_req r);
            t_res res;
            int   hit;
            res = '0;
            res.status = ST_NOT_FOUND;
            hit = find_key(r.ls_id, r.adv_rtr);
            case (r.req_type)
                REQ_LOOKUP: begin
                    if (hit >= 0) begin
                        res.status     = ST_FOUND;
                        res.found_kind = entries[hit].lsa_kind;
                        res.found_seq  = entries[hit].seq_number;
                        res.found_age  = entries[hit].lsa_age;
                    end
                end
                REQ_ADD: begin
                    if (hit >= 0) begin
                        entries[hit].lsa_kind   = r.lsa_kind;
                        entries[hit].seq_number = r.seq_number;
                        entries[hit].lsa_age    = r.lsa_age;
                        res.status = ST_UPDATED;
                    end else if (used < MAX_ENTRIES) begin
                        entries[used].ls_id      = r.ls_id;
                        entries[used].adv_rtr    = r.adv_rtr;
                        entries[used].lsa_kind   = r.lsa_kind;
                        entries[used].seq_number = r.seq_number;
                        entries[used].lsa_age    = r.lsa_age;
                        used++;
                        res.status = ST_ADDED;
                    end else begin
                        res.status = ST_FULL;
                    end
                end
                REQ_REMOVE: begin
                    if (hit >= 0) begin
                        // Later entries move down one place so the scan order is kept.
                        for (int j = hit; j + 1 < used; j++)
                            entries[j] = entries[j + 1];
                        used--;
                        res.status = ST_REMOVED;
                    end
                end
                default: ;
            endcase
            res.entry_count = ENTRY_CNT_W'(used);
            expected_results.push_back(res);
        endfunction

        function void check_result(t_res got);
            t_res want;
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("%0t: result with nothing expected: status %0d count %0d",
                             $realtime, got.status, got.entry_count);
                return;
            end
            want = expected_results.pop_front();
            if (got.status !== want.status || got.found_kind !== want.found_kind ||
                got.found_seq !== want.found_seq || got.found_age !== want.found_age ||
                got.entry_count !== want.entry_count) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT) begin
                    $display("%0t: mismatch, expected status %0d kind %h seq %h age %h count %0d",
                             $realtime, want.status, want.found_kind, want.found_seq,
                             want.found_age, want.entry_count);
                    $display("%0t:                got status %0d kind %h seq %h age %h count %0d",
                             $realtime, got.status, got.found_kind, got.found_seq,
                             got.found_age, got.entry_count);
                end
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    lst_req_if req_if ();
    lst_res_if res_if ();

    link_state_table u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    link_table_model lsdb = new();

    int          send_idle_pct;
    int          stall_pct;
    logic [31:0] pool_id[KEY_POOL];
    logic [31:0] pool_rtr[KEY_POOL];

    // Kind and age come in as 32-bit words and only their low bits are kept.
    function automatic t_req make_req(logic [1:0] req, logic [31:0] id, logic [31:0] rtr,
                                      logic [31:0] kind, logic [31:0] seq,
                                      logic [31:0] age);
        t_req r;
        r.req_type   = req;
        r.ls_id      = id;
        r.adv_rtr    = rtr;
        r.lsa_kind   = kind[7:0];
        r.seq_number = seq;
        r.lsa_age    = age[15:0];
        return r;
    endfunction

    task automatic send_request(input t_req r);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= r;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        lsdb.note_request(r);
    endtask

    // Adds every pool key in turn; the pool is larger than the table, so the
    // last adds find it full.
    task automatic fill_table();
        for (int i = 0; i < KEY_POOL; i++)
            send_request(make_req(REQ_ADD, pool_id[i], pool_rtr[i],
                                  $urandom, $urandom, $urandom));
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Result side: check every transfer, then pick ready for the next edge.
    initial begin
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (res_if.valid === 1'b1 && res_if.ready === 1'b1)
                lsdb.check_result(res_if.data);
            res_if.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    initial begin
        int          sel;
        int          add_pct;
        int          remove_pct;
        int          k;
        logic [1:0]  req;
        logic [31:0] id;
        logic [31:0] rtr;

        i_rst_n       <= 1'b0;
        req_if.valid  <= 1'b0;
        req_if.data   <= '0;
        send_idle_pct = 0;
        stall_pct     = 0;

        // Some pool keys share one half with a neighbor to catch half-key matches.
        for (int i = 0; i < KEY_POOL; i++) begin
            pool_id[i]  = (i % 4 == 1) ? pool_id[i - 1] : $urandom;
            pool_rtr[i] = (i % 4 == 2) ? pool_rtr[i - 1] : $urandom;
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty table, key extremes, update, ignored fields, removes.
        send_request(make_req(REQ_LOOKUP, '0, '0, $urandom, $urandom, $urandom));
        send_request(make_req(REQ_REMOVE, '0, '0, $urandom, $urandom, $urandom));
        send_request(make_req(REQ_UNKNOWN, '0, '0, $urandom, $urandom, $urandom));
        send_request(make_req(REQ_ADD, '0, '0, '0, '0, '0));
        send_request(make_req(REQ_ADD, '1, '1, '1, '1, '1));
        send_request(make_req(REQ_ADD, '1, '0, 32'h0000_00a5, 32'h5a5a_a5a5, 32'h0000_5aa5));
        send_request(make_req(REQ_ADD, '0, '1, 32'h0000_005a, 32'ha5a5_5a5a, 32'h0000_a55a));
        send_request(make_req(REQ_LOOKUP, '1, '1, '0, '0, '0));
        send_request(make_req(REQ_LOOKUP, '0, '0, '1, '1, '1));
        send_request(make_req(REQ_LOOKUP, '1, '0, $urandom, $urandom, $urandom));
        send_request(make_req(REQ_ADD, '0, '0, '1, '1, '1));
        send_request(make_req(REQ_LOOKUP, '0, '0, $urandom, $urandom, $urandom));
        send_request(make_req(REQ_UNKNOWN, '0, '0, $urandom, $urandom, $urandom));
        send_request(make_req(REQ_REMOVE, '0, '0, $urandom, $urandom, $urandom));
        send_request(make_req(REQ_LOOKUP, '1, '1, $urandom, $urandom, $urandom));
        send_request(make_req(REQ_REMOVE, '0, '1, $urandom, $urandom, $urandom));
        send_request(make_req(REQ_REMOVE, '0, '1, $urandom, $urandom, $urandom));
        send_request(make_req(REQ_LOOKUP, '0, '1, $urandom, $urandom, $urandom));
        send_request(make_req(REQ_REMOVE, '1, '0, $urandom, $urandom, $urandom));
        send_request(make_req(REQ_REMOVE, '1, '1, $urandom, $urandom, $urandom));
        send_request(make_req(REQ_LOOKUP, '1, '1, $urandom, $urandom, $urandom));

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  stall_pct = 0;  add_pct = 50; remove_pct = 30; end
                1: begin send_idle_pct = 48; stall_pct = 0;  add_pct = 30; remove_pct = 20; end
                2: begin send_idle_pct = 0;  stall_pct = 48; add_pct = 20; remove_pct = 60; end
                default: begin
                    send_idle_pct = 20; stall_pct = 20; add_pct = 40; remove_pct = 20;
                end
            endcase
            if (phase == 1 || phase == 3)
                fill_table();
            for (int n = 0; n < 70; n++) begin
                sel = $urandom_range(0, 99);
                if (sel < add_pct)
                    req = REQ_ADD;
                else if (sel < add_pct + remove_pct)
                    req = REQ_REMOVE;
                else if (sel < 97)
                    req = REQ_LOOKUP;
                else
                    req = REQ_UNKNOWN;
                if ($urandom_range(0, 9) == 0) begin
                    id  = $urandom;
                    rtr = $urandom;
                end else begin
                    k   = $urandom_range(0, KEY_POOL - 1);
                    id  = pool_id[k];
                    rtr = pool_rtr[k];
                end
                send_request(make_req(req, id, rtr, $urandom, $urandom, $urandom));
            end
        end

        req_if.valid <= 1'b0;
        while (lsdb.expected_results.size() != 0)
            @(posedge i_clk);
        repeat (2 * MAX_ENTRIES + 8) @(posedge i_clk);

        if (lsdb.mismatch_count == 0 && lsdb.expected_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
